// ===== rtl/box_filter_3x3_rgb_macros.svh =====
// ----------------------------------------------------------------------------
// box_filter_3x3_rgb assertion macros
// Shared concurrent assertion forms, removed when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef BOX_FILTER_3X3_RGB_MACROS_SVH
`define BOX_FILTER_3X3_RGB_MACROS_SVH
`ifndef NO_ASSERTIONS
// condition that must hold at every clock edge out of reset
`define BFR_ASSERT(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
		else $error("box filter assertion failed");
// condition that must hold in the cycle after the trigger
`define BFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("box filter assertion failed");
`else
`define BFR_ASSERT(label, clk, rst_n, expr)
`define BFR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/bfr_pkg.sv =====
// ----------------------------------------------------------------------------
// bfr_pkg
// Types, constants and helpers shared by the box filter modules.
// ----------------------------------------------------------------------------
package bfr_pkg;

	// frame geometry
	localparam int MAX_WIDTH    = 2048;
	localparam int HEIGHT_LIMIT = 4096;
	localparam int COL_W        = $clog2(MAX_WIDTH);
	localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
	localparam int WIDTH_W      = 12;
	localparam int HEIGHT_W     = 13;
	localparam int CFG_DATA_W   = HEIGHT_W;
	localparam int PEND_W       = WIDTH_W;

	// pixel and arithmetic
	localparam int CH_W     = 8;
	localparam int PIX_W    = 3 * CH_W;
	localparam int SUM_W    = 12;
	localparam int RECIP_W  = 12;
	localparam int PROD_W   = SUM_W + RECIP_W;
	localparam int RECIP_SHIFT = 15;
	localparam logic [RECIP_W-1:0] RECIP_9 = 12'd3641;

	// queues
	localparam int OPQ_DEPTH = 4;
	localparam int OPQ_PTR_W = $clog2(OPQ_DEPTH);
	localparam int RESQ_DEPTH = 8;
	localparam int RESQ_PTR_W = $clog2(RESQ_DEPTH);

	// codes
	localparam logic CMD_PIXEL  = 1'b0;
	localparam logic CMD_DRAIN  = 1'b1;
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// reset values of the registers
	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

	typedef logic [PIX_W-1:0] pixel_t;

	// one classified item handed to the back end
	typedef struct packed {
		logic             write;
		logic             emit;
		logic             interior;
		logic             last;
		logic             single_row;
		logic [1:0]       row_sel;
		logic [COL_W-1:0] col;
		pixel_t           pixel;
	} op_t;

	typedef struct packed {
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
		logic            frame_end;
	} result_t;

	// next line buffer in the three-way rotation
	function automatic logic [1:0] row_next(input logic [1:0] r);
		logic [1:0] n;
		case (r)
			2'd0: n = 2'd1;
			2'd1: n = 2'd2;
			default: n = 2'd0;
		endcase
		return n;
	endfunction

endpackage

// ===== rtl/box_filter_3x3_rgb.sv =====
// ----------------------------------------------------------------------------
// box_filter_3x3_rgb
// 3x3 mean filter over a raster stream of RGB pixels, border pass-through.
//
//   channel   direction  handshake             payload
//   input     in         push / full           command, blue_in, green_in,
//                                              red_in
//   result    out        empty / pop           blue_out, green_out, red_out,
//                                              frame_end
//   config    in         cfg_we                cfg_index, cfg_data
//
// One transaction is taken per cycle while full is low; the line buffers give
// one read and one write per cycle, which sets that rate. A result goes from
// the operation queue through stages s1 to s4 into the result queue.
// Reset clears position counters and queues; line buffers hold no reset.
// full rises only when the operation queue fills, which happens when the
// eight-entry result queue is fully reserved and the consumer does not pop.
// ----------------------------------------------------------------------------
module box_filter_3x3_rgb import bfr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  push,
	output logic                  full,
	input  logic                  command,
	input  logic [CH_W-1:0]       blue_in,
	input  logic [CH_W-1:0]       green_in,
	input  logic [CH_W-1:0]       red_in,
	output logic                  empty,
	input  logic                  pop,
	output logic [CH_W-1:0]       blue_out,
	output logic [CH_W-1:0]       green_out,
	output logic [CH_W-1:0]       red_out,
	output logic                  frame_end
);

	logic op_valid;
	op_t  op;
	logic op_pop;

	// position tracking and classification
	bfr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.full      (full),
		.command   (command),
		.blue_in   (blue_in),
		.green_in  (green_in),
		.red_in    (red_in),
		.op_valid  (op_valid),
		.op        (op),
		.op_pop    (op_pop)
	);

	// line buffers, window and arithmetic
	bfr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op        (op),
		.op_pop    (op_pop),
		.pop       (pop),
		.empty     (empty),
		.blue_out  (blue_out),
		.green_out (green_out),
		.red_out   (red_out),
		.frame_end (frame_end)
	);

endmodule

// ===== rtl/bfr_ram.sv =====
// ----------------------------------------------------------------------------
// bfr_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module bfr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/bfr_front.sv =====
// ----------------------------------------------------------------------------
// bfr_front
// Accepts items, tracks frame position, decides which transactions shift the
// window and which produce a result, and queues the classified operations.
// ----------------------------------------------------------------------------
`include "box_filter_3x3_rgb_macros.svh"

module bfr_front import bfr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  push,
	output logic                  full,
	input  logic                  command,
	input  logic [CH_W-1:0]       blue_in,
	input  logic [CH_W-1:0]       green_in,
	input  logic [CH_W-1:0]       red_in,
	output logic                  op_valid,
	output op_t                   op,
	input  logic                  op_pop
);

	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [WIDTH_W-1:0]  w_eff;
	logic [HEIGHT_W-1:0] h_eff;

	logic [COL_W-1:0]  pc_q;
	logic [1:0]        rm_q;
	logic [ROW_W-1:0]  in_row_q;
	logic              done_q;
	logic [PEND_W-1:0] pend_q;
	logic [COL_W-1:0]  ocol_q;
	logic [ROW_W-1:0]  orow_q;

	logic acc, is_pixel, is_flush, shift, emit;
	logic pc_last, in_row_last, ocol_last, orow_last, pend_full;
	logic interior, last;
	logic pend_ok;
	op_t  op_new;

	op_t                 opq_q [OPQ_DEPTH];
	logic [OPQ_PTR_W-1:0] opq_wr_q, opq_rd_q;
	logic [OPQ_PTR_W:0]   opq_cnt_q;

	// register values clamped to the supported range
	always_comb begin
		if (width_q == '0)
			w_eff = WIDTH_W'(1);
		else if (width_q > WIDTH_W'(MAX_WIDTH))
			w_eff = WIDTH_W'(MAX_WIDTH);
		else
			w_eff = width_q;
		if (height_q == '0)
			h_eff = HEIGHT_W'(1);
		else if (height_q > HEIGHT_W'(HEIGHT_LIMIT))
			h_eff = HEIGHT_W'(HEIGHT_LIMIT);
		else
			h_eff = height_q;
	end

	// position compares
	assign pc_last     = ({1'b0, pc_q} == (w_eff - WIDTH_W'(1)));
	assign ocol_last   = ({1'b0, ocol_q} == (w_eff - WIDTH_W'(1)));
	assign in_row_last = ({1'b0, in_row_q} == (h_eff - HEIGHT_W'(1)));
	assign orow_last   = ({1'b0, orow_q} == (h_eff - HEIGHT_W'(1)));
	assign pend_full   = ({1'b0, pend_q} >= ({1'b0, w_eff} + HEIGHT_W'(1)));
	assign interior    = (orow_q != '0) && (ocol_q != '0)
		&& (({1'b0, orow_q} + HEIGHT_W'(2)) <= h_eff)
		&& (({1'b0, ocol_q} + WIDTH_W'(2)) <= w_eff);
	assign last        = ocol_last && orow_last;
	assign pend_ok     = ({1'b0, pend_q} <= ({1'b0, w_eff} + HEIGHT_W'(1)));

	// classification of the accepted transaction
	assign acc      = push && !full;
	assign is_pixel = acc && (command == CMD_PIXEL) && !done_q;
	assign is_flush = acc && !is_pixel && done_q && (pend_q != '0);
	assign shift    = is_pixel || is_flush;
	assign emit     = (is_pixel && pend_full) || is_flush;

	always_comb begin
		op_new            = '0;
		op_new.write      = is_pixel;
		op_new.emit       = emit;
		op_new.interior   = interior;
		op_new.last       = last;
		op_new.single_row = (h_eff == HEIGHT_W'(1));
		op_new.row_sel    = rm_q;
		op_new.col        = pc_q;
		op_new.pixel      = {red_in, green_in, blue_in};
	end

	// configuration and frame position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			pc_q     <= '0;
			rm_q     <= '0;
			in_row_q <= '0;
			done_q   <= 1'b0;
			pend_q   <= '0;
			ocol_q   <= '0;
			orow_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[WIDTH_W-1:0];
				REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
			pc_q     <= '0;
			rm_q     <= '0;
			in_row_q <= '0;
			done_q   <= 1'b0;
			pend_q   <= '0;
			ocol_q   <= '0;
			orow_q   <= '0;
		end else begin
			if (shift) begin
				if (pc_last) begin
					pc_q <= '0;
					rm_q <= row_next(rm_q);
				end else begin
					pc_q <= pc_q + COL_W'(1);
				end
			end
			if (is_pixel && pc_last) begin
				if (in_row_last) begin
					in_row_q <= '0;
					done_q   <= 1'b1;
				end else begin
					in_row_q <= in_row_q + ROW_W'(1);
				end
			end
			if (is_pixel && !emit)
				pend_q <= pend_q + PEND_W'(1);
			else if (is_flush)
				pend_q <= pend_q - PEND_W'(1);
			if (emit) begin
				if (last) begin
					pc_q     <= '0;
					rm_q     <= '0;
					in_row_q <= '0;
					done_q   <= 1'b0;
					pend_q   <= '0;
					ocol_q   <= '0;
					orow_q   <= '0;
				end else if (ocol_last) begin
					ocol_q <= '0;
					orow_q <= orow_q + ROW_W'(1);
				end else begin
					ocol_q <= ocol_q + COL_W'(1);
				end
			end
		end
	end

	// operation queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opq_wr_q  <= '0;
			opq_rd_q  <= '0;
			opq_cnt_q <= '0;
		end else begin
			if (shift)
				opq_wr_q <= opq_wr_q + OPQ_PTR_W'(1);
			if (op_pop)
				opq_rd_q <= opq_rd_q + OPQ_PTR_W'(1);
			if (shift && !op_pop)
				opq_cnt_q <= opq_cnt_q + (OPQ_PTR_W+1)'(1);
			else if (!shift && op_pop)
				opq_cnt_q <= opq_cnt_q - (OPQ_PTR_W+1)'(1);
		end
	end

	// operation queue storage
	always_ff @(posedge clk) begin
		if (shift)
			opq_q[opq_wr_q] <= op_new;
	end

	assign full     = (opq_cnt_q == (OPQ_PTR_W+1)'(OPQ_DEPTH));
	assign op_valid = (opq_cnt_q != '0);
	assign op       = opq_q[opq_rd_q];

	`BFR_ASSERT(a_pend_bound, clk, arst_n, pend_ok)
	`BFR_ASSERT(a_opq_bound, clk, arst_n, opq_cnt_q <= (OPQ_PTR_W+1)'(OPQ_DEPTH))
	`BFR_ASSERT(a_pop_needs_op, clk, arst_n, !op_pop || op_valid)

endmodule

// ===== rtl/bfr_back.sv =====
// ----------------------------------------------------------------------------
// bfr_back
// Line buffers, 3x3 window, per-channel sum and divide by nine, and the
// result queue that feeds the output side.
// ----------------------------------------------------------------------------
`include "box_filter_3x3_rgb_macros.svh"

module bfr_back import bfr_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            op_valid,
	input  op_t             op,
	output logic            op_pop,
	input  logic            pop,
	output logic            empty,
	output logic [CH_W-1:0] blue_out,
	output logic [CH_W-1:0] green_out,
	output logic [CH_W-1:0] red_out,
	output logic            frame_end
);

	logic [RESQ_PTR_W:0] reserved_q;
	logic                credit_ok;
	pixel_t              rd_data [3];

	logic   v_s1;
	op_t    op_s1;
	logic [1:0] top_sel, mid_sel;
	pixel_t top_pix, mid_pix;
	pixel_t win_q [3][3];

	logic v_s2, interior_s2, last_s2, single_s2;
	logic [SUM_W-1:0] sum_d [3];
	pixel_t pass_d;

	logic v_s3, interior_s3, last_s3;
	logic [SUM_W-1:0] sum_s3 [3];
	pixel_t pass_s3;

	logic v_s4, interior_s4, last_s4;
	logic [PROD_W-1:0] prod_s4 [3];
	pixel_t pass_s4;
	result_t res_new;

	result_t resq_q [RESQ_DEPTH];
	logic [RESQ_PTR_W-1:0] resq_wr_q, resq_rd_q;
	logic [RESQ_PTR_W:0]   resq_cnt_q;
	logic res_pop;

	// take an operation when the result queue has room for what it yields
	assign credit_ok = (reserved_q < (RESQ_PTR_W+1)'(RESQ_DEPTH));
	assign op_pop    = op_valid && (!op.emit || credit_ok);

	// three line buffers in rotation, one per row modulo three
	for (genvar k = 0; k < 3; k++) begin : g_line
		bfr_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram (
			.clk   (clk),
			.we    (op_pop && op.write && (op.row_sel == 2'(k))),
			.waddr (op.col),
			.wdata (op.pixel),
			.re    (op_pop),
			.raddr (op.col),
			.rdata (rd_data[k])
		);
	end

	// row selection for the two older rows
	assign top_sel = row_next(op_s1.row_sel);
	assign mid_sel = row_next(top_sel);

	always_comb begin
		case (top_sel)
			2'd0: top_pix = rd_data[0];
			2'd1: top_pix = rd_data[1];
			default: top_pix = rd_data[2];
		endcase
		case (mid_sel)
			2'd0: mid_pix = rd_data[0];
			2'd1: mid_pix = rd_data[1];
			default: mid_pix = rd_data[2];
		endcase
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= op_pop;
			v_s2 <= v_s1 && op_s1.emit;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// window shift, columns oldest to newest, rows top to bottom
	always_ff @(posedge clk) begin
		op_s1 <= op;
		if (v_s1) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2][0] <= top_pix;
			win_q[2][1] <= mid_pix;
			win_q[2][2] <= op_s1.pixel;
		end
		interior_s2 <= op_s1.interior;
		last_s2     <= op_s1.last;
		single_s2   <= op_s1.single_row;
	end

	// neighbourhood sums and pass-through pixel
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			sum_d[ch] = '0;
			for (int c = 0; c < 3; c++)
				for (int r = 0; r < 3; r++)
					sum_d[ch] = sum_d[ch] + SUM_W'(win_q[c][r][ch*CH_W +: CH_W]);
		end
		pass_d = single_s2 ? win_q[2][1] : win_q[1][1];
	end

	// sum, then multiply by the reciprocal of nine
	always_ff @(posedge clk) begin
		sum_s3      <= sum_d;
		pass_s3     <= pass_d;
		interior_s3 <= interior_s2;
		last_s3     <= last_s2;
		for (int ch = 0; ch < 3; ch++)
			prod_s4[ch] <= PROD_W'(sum_s3[ch]) * PROD_W'(RECIP_9);
		pass_s4     <= pass_s3;
		interior_s4 <= interior_s3;
		last_s4     <= last_s3;
	end

	// final selection between mean and original pixel
	always_comb begin
		if (interior_s4) begin
			res_new.blue  = prod_s4[0][RECIP_SHIFT +: CH_W];
			res_new.green = prod_s4[1][RECIP_SHIFT +: CH_W];
			res_new.red   = prod_s4[2][RECIP_SHIFT +: CH_W];
		end else begin
			res_new.blue  = pass_s4[0 +: CH_W];
			res_new.green = pass_s4[CH_W +: CH_W];
			res_new.red   = pass_s4[2*CH_W +: CH_W];
		end
		res_new.frame_end = last_s4;
	end

	// result queue and slot reservation
	assign res_pop = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resq_wr_q  <= '0;
			resq_rd_q  <= '0;
			resq_cnt_q <= '0;
			reserved_q <= '0;
		end else begin
			if (v_s4)
				resq_wr_q <= resq_wr_q + RESQ_PTR_W'(1);
			if (res_pop)
				resq_rd_q <= resq_rd_q + RESQ_PTR_W'(1);
			if (v_s4 && !res_pop)
				resq_cnt_q <= resq_cnt_q + (RESQ_PTR_W+1)'(1);
			else if (!v_s4 && res_pop)
				resq_cnt_q <= resq_cnt_q - (RESQ_PTR_W+1)'(1);
			if ((op_pop && op.emit) && !res_pop)
				reserved_q <= reserved_q + (RESQ_PTR_W+1)'(1);
			else if (!(op_pop && op.emit) && res_pop)
				reserved_q <= reserved_q - (RESQ_PTR_W+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (v_s4)
			resq_q[resq_wr_q] <= res_new;
	end

	assign empty     = (resq_cnt_q == '0);
	assign blue_out  = resq_q[resq_rd_q].blue;
	assign green_out = resq_q[resq_rd_q].green;
	assign red_out   = resq_q[resq_rd_q].red;
	assign frame_end = resq_q[resq_rd_q].frame_end;

	`BFR_ASSERT(a_res_within_reserved, clk, arst_n, resq_cnt_q <= reserved_q)
	`BFR_ASSERT(a_reserved_bound, clk, arst_n, reserved_q <= (RESQ_PTR_W+1)'(RESQ_DEPTH))
	`BFR_ASSERT_NEXT(a_emit_reserves, clk, arst_n, op_pop && op.emit, reserved_q != '0)

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 3x3 RGB box filter. A directed table covers
// pass-through frames, the interior mean, early and empty drains, and pixels
// sent after a complete frame. Random frames of many geometries follow,
// including clamped and zero sizes. Every result is checked against a value
// from the table or a behavioural mean filter that keeps its own copy of the
// recent pixel history and frame position. Both handshakes see random gaps.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bfr_pkg::*;

	localparam int HISTORY_DEPTH = 2 * MAX_WIDTH + 3;
	localparam int SETTLE_CYCLES = 20;

	typedef enum logic [1:0] {ROW_CFG, ROW_ITEM} row_kind_t;
	typedef enum logic [1:0] {CHK_PRED, CHK_NONE, CHK_RES} row_check_t;

	typedef struct {
		row_kind_t  kind;
		logic       reg_sel;
		logic [CFG_DATA_W-1:0] reg_val;
		logic       cmd;
		pixel_t     px;
		row_check_t chk;
		result_t    res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = REG_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic push = 1'b0;
	logic full;
	logic command = CMD_PIXEL;
	logic [CH_W-1:0] blue_in = '0;
	logic [CH_W-1:0] green_in = '0;
	logic [CH_W-1:0] red_in = '0;
	logic empty;
	logic pop = 1'b0;
	logic [CH_W-1:0] blue_out;
	logic [CH_W-1:0] green_out;
	logic [CH_W-1:0] red_out;
	logic frame_end;

	bit failed = 1'b0;
	result_t pending_pixels[$];
	stim_row_t stim_table[$];
	int items_sent = 0;

	// filter state mirrored by the bench
	logic [WIDTH_W-1:0] width_reg = WIDTH_RESET;
	logic [HEIGHT_W-1:0] height_reg = HEIGHT_RESET;
	pixel_t pixel_history [HISTORY_DEPTH];
	int unsigned hist_wr = 0;
	int unsigned in_col = 0, in_row = 0, out_pos = 0, out_col = 0, out_row = 0;
	bit in_complete = 1'b0;

	box_filter_3x3_rgb dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.push(push), .full(full), .command(command),
		.blue_in(blue_in), .green_in(green_in), .red_in(red_in),
		.empty(empty), .pop(pop),
		.blue_out(blue_out), .green_out(green_out), .red_out(red_out),
		.frame_end(frame_end)
	);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// effective geometry after clamping
	function automatic int unsigned frame_w();
		if (width_reg == 0) return 1;
		if (width_reg > MAX_WIDTH) return MAX_WIDTH;
		return width_reg;
	endfunction

	function automatic int unsigned frame_h();
		if (height_reg == 0) return 1;
		if (height_reg > HEIGHT_LIMIT) return HEIGHT_LIMIT;
		return height_reg;
	endfunction

	function automatic int unsigned pixels_in();
		return in_complete ? frame_w() * frame_h() : in_row * frame_w() + in_col;
	endfunction

	function automatic pixel_t history_at(int unsigned back);
		if (back == 0 || back > HISTORY_DEPTH) return '0;
		return pixel_history[(hist_wr + HISTORY_DEPTH - back) % HISTORY_DEPTH];
	endfunction

	task automatic restart_position();
		in_col = 0; in_row = 0; in_complete = 1'b0;
		out_pos = 0; out_col = 0; out_row = 0;
	endtask

	// next output pixel: mean of the original 3x3 window, or the pixel itself on a border
	task automatic next_mean(output result_t res);
		int unsigned w, h, got, x, sb, sg, sr;
		pixel_t p;
		w = frame_w();
		h = frame_h();
		got = pixels_in();
		if (out_row >= 1 && out_row + 2 <= h && out_col >= 1 && out_col + 2 <= w) begin
			sb = 0; sg = 0; sr = 0;
			for (int dr = 0; dr < 3; dr++)
				for (int dc = 0; dc < 3; dc++) begin
					x = out_pos + dr * w + dc - w - 1;
					p = history_at(got - x);
					sb += p[7:0];
					sg += p[15:8];
					sr += p[23:16];
				end
			res.blue = CH_W'(sb / 9);
			res.green = CH_W'(sg / 9);
			res.red = CH_W'(sr / 9);
		end else begin
			p = history_at(got - out_pos);
			res.blue = p[7:0];
			res.green = p[15:8];
			res.red = p[23:16];
		end
		res.frame_end = (out_pos + 1 >= w * h);
		if (res.frame_end) begin
			restart_position();
		end else begin
			out_pos++;
			out_col++;
			if (out_col >= w) begin
				out_col = 0;
				out_row++;
			end
		end
	endtask

	task automatic mean_filter_predict(input logic cmd, input pixel_t px,
			output bit has_res, output result_t res);
		int unsigned w;
		w = frame_w();
		has_res = 1'b0;
		if (cmd == CMD_PIXEL && !in_complete) begin
			pixel_history[hist_wr] = px;
			hist_wr = (hist_wr + 1) % HISTORY_DEPTH;
			in_col++;
			if (in_col >= w) begin
				in_col = 0;
				in_row++;
				if (in_row >= frame_h()) begin
					in_row = 0;
					in_complete = 1'b1;
				end
			end
			if (pixels_in() - out_pos >= w + 2) begin
				next_mean(res);
				has_res = 1'b1;
			end
		end else if (in_complete && pixels_in() > out_pos) begin
			next_mean(res);
			has_res = 1'b1;
		end
	endtask

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70) return 0;
		if (roll < 96) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [CH_W-1:0] rand_channel();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return CH_W'($urandom_range(0, 255));
		endcase
	endfunction

	// one input transaction; the prediction is taken when it is accepted
	task automatic send_item(input logic cmd, input pixel_t px, input int gap,
			input row_check_t chk, input result_t typed);
		bit has_res;
		result_t res;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		command <= cmd;
		blue_in <= px[7:0];
		green_in <= px[15:8];
		red_in <= px[23:16];
		do @(posedge clk); while (full);
		items_sent++;
		mean_filter_predict(cmd, px, has_res, res);
		if (chk == CHK_PRED) begin
			if (has_res) pending_pixels.push_back(res);
		end else if (chk == CHK_RES) begin
			pending_pixels.push_back(typed);
		end
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
	endtask

	// register write, only with the block idle
	task automatic write_reg(input logic sel, input logic [CFG_DATA_W-1:0] val);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (sel == REG_WIDTH) width_reg = val[WIDTH_W-1:0];
		else height_reg = val;
		restart_position();
	endtask

	task automatic row_cfg(input logic sel, input int val);
		stim_row_t r;
		r.kind = ROW_CFG; r.reg_sel = sel; r.reg_val = CFG_DATA_W'(val);
		r.cmd = CMD_PIXEL; r.px = '0; r.chk = CHK_PRED; r.res = '0;
		stim_table.push_back(r);
	endtask

	task automatic row_item(input logic cmd, input pixel_t px, input row_check_t chk,
			input result_t res);
		stim_row_t r;
		r.kind = ROW_ITEM; r.reg_sel = REG_WIDTH; r.reg_val = '0;
		r.cmd = cmd; r.px = px; r.chk = chk; r.res = res;
		stim_table.push_back(r);
	endtask

	// result side: check each transaction, random pop gaps
	int pop_hold = 0;
	int calm_left = 0;
	always @(posedge clk) begin
		result_t exp_res;
		if (arst_n) begin
			if (pop && !empty) begin
				if (pending_pixels.size() == 0) begin
					$error("result with nothing expected");
					failed = 1'b1;
				end else begin
					exp_res = pending_pixels.pop_front();
					if (blue_out !== exp_res.blue) begin
						$error("blue_out: expected %0d, got %0d", exp_res.blue, blue_out);
						failed = 1'b1;
					end
					if (green_out !== exp_res.green) begin
						$error("green_out: expected %0d, got %0d", exp_res.green, green_out);
						failed = 1'b1;
					end
					if (red_out !== exp_res.red) begin
						$error("red_out: expected %0d, got %0d", exp_res.red, red_out);
						failed = 1'b1;
					end
					if (frame_end !== exp_res.frame_end) begin
						$error("frame_end: expected %0d, got %0d",
							exp_res.frame_end, frame_end);
						failed = 1'b1;
					end
				end
			end
			if (calm_left > 0) begin
				calm_left <= calm_left - 1;
				pop <= 1'b1;
			end else if (pop_hold > 0) begin
				pop_hold <= pop_hold - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
				if ($urandom_range(0, 199) == 0) calm_left <= $urandom_range(50, 200);
				else if ($urandom_range(0, 4) == 0) pop_hold <= pick_gap();
			end
		end
	end

	// overall time limit
	initial begin
		#50_000_000;
		$display("tb_top failed");
		$finish;
	end

	// stimulus
	initial begin
		result_t none;
		int unsigned w, h, frames, cut;
		bit paused;
		none = '0;
		paused = 1'b0;

		// narrow single row: pure pass-through, then early and empty drains
		row_cfg(REG_WIDTH, 3);
		row_cfg(REG_HEIGHT, 1);
		row_item(CMD_PIXEL, 24'h000000, CHK_NONE, none);
		row_item(CMD_PIXEL, 24'hffffff, CHK_NONE, none);
		row_item(CMD_PIXEL, 24'h123456, CHK_NONE, none);
		row_item(CMD_DRAIN, '0, CHK_RES, '{8'h00, 8'h00, 8'h00, 1'b0});
		row_item(CMD_DRAIN, '0, CHK_RES, '{8'hff, 8'hff, 8'hff, 1'b0});
		row_item(CMD_DRAIN, '0, CHK_RES, '{8'h56, 8'h34, 8'h12, 1'b1});
		row_item(CMD_DRAIN, '0, CHK_NONE, none);
		row_item(CMD_PIXEL, 24'hffffff, CHK_NONE, none);
		row_item(CMD_DRAIN, '0, CHK_NONE, none);
		// 3x3 frame: one interior pixel, then a pixel after the frame acts as a drain
		row_cfg(REG_HEIGHT, 3);
		row_item(CMD_PIXEL, 24'hffffff, CHK_PRED, none);
		row_item(CMD_PIXEL, 24'hffffff, CHK_PRED, none);
		row_item(CMD_PIXEL, 24'h000000, CHK_PRED, none);
		row_item(CMD_PIXEL, 24'hffffff, CHK_PRED, none);
		row_item(CMD_PIXEL, 24'h80ff01, CHK_PRED, none);
		row_item(CMD_PIXEL, 24'hffffff, CHK_PRED, none);
		row_item(CMD_PIXEL, 24'h7f00fe, CHK_PRED, none);
		row_item(CMD_PIXEL, 24'hffffff, CHK_PRED, none);
		row_item(CMD_PIXEL, 24'hffffff, CHK_PRED, none);
		row_item(CMD_PIXEL, 24'h555555, CHK_PRED, none);
		row_item(CMD_DRAIN, '0, CHK_PRED, none);
		row_item(CMD_DRAIN, '0, CHK_PRED, none);
		row_item(CMD_DRAIN, '0, CHK_PRED, none);
		row_item(CMD_DRAIN, '0, CHK_PRED, none);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_table[i]) begin
			if (stim_table[i].kind == ROW_CFG)
				write_reg(stim_table[i].reg_sel, stim_table[i].reg_val);
			else
				send_item(stim_table[i].cmd, stim_table[i].px, pick_gap(),
					stim_table[i].chk, stim_table[i].res);
		end

		// random frames; the first phases take the clamped and zero sizes
		for (int phase = 0; phase < 6 || items_sent < 1650; phase++) begin
			case (phase)
				0: begin w = 4095; h = 2; end
				1: begin w = 0; h = 0; end
				2: begin w = 1; h = 8191; end
				3: begin w = 2048; h = 3; end
				4: begin w = 1; h = 1; end
				5: begin w = 2; h = 4096; end
				default: begin
					w = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 9);
					h = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
				end
			endcase
			if ($urandom_range(0, 1)) begin
				write_reg(REG_WIDTH, {1'($urandom_range(0, 1)), 12'(w)});
				write_reg(REG_HEIGHT, CFG_DATA_W'(h));
			end else begin
				write_reg(REG_HEIGHT, CFG_DATA_W'(h));
				write_reg(REG_WIDTH, {1'($urandom_range(0, 1)), 12'(w)});
			end
			w = frame_w();
			h = frame_h();
			frames = $urandom_range(1, 3);
			for (int f = 0; f < frames; f++) begin
				// a broken frame stops part way and is dropped by the next restart
				cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, w * h - 1) : w * h;
				// very large frames only get a short opening stretch
				if (w * h > 256) cut = $urandom_range(1, 48);
				for (int unsigned p = 0; p < cut; p++) begin
					if ($urandom_range(0, 11) == 0)
						send_item(CMD_DRAIN, {rand_channel(), rand_channel(), rand_channel()},
							pick_gap(), CHK_PRED, none);
					send_item(CMD_PIXEL, {rand_channel(), rand_channel(), rand_channel()},
						pick_gap(), CHK_PRED, none);
					// hold the sender until the result side has caught up
					if (!paused && items_sent > 700) begin
						wait_drained();
						paused = 1'b1;
					end
				end
				if (cut < w * h) break;
				while (in_complete && pixels_in() > out_pos)
					send_item(($urandom_range(0, 5) == 0) ? CMD_PIXEL : CMD_DRAIN,
						{rand_channel(), rand_channel(), rand_channel()},
						pick_gap(), CHK_PRED, none);
				repeat ($urandom_range(0, 2))
					send_item(CMD_DRAIN, '0, pick_gap(), CHK_PRED, none);
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (!failed && pending_pixels.size() == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule

// ===== box_filter_3x3_rgb.f =====
+incdir+rtl
rtl/bfr_pkg.sv
rtl/bfr_ram.sv
rtl/bfr_front.sv
rtl/bfr_back.sv
rtl/box_filter_3x3_rgb.sv
tb/tb_top.sv
